### rtl/ttbd_pkg.sv
package ttbd_pkg;

    localparam int SCORE_W       = 16;
    localparam int STEP_W        = 6;
    localparam int MIN_TILE      = 5;
    localparam int DEF_TILE      = 10;
    localparam int MIN_LAYERS    = 5;
    localparam int THRESH_OFFSET = 200;
    localparam int PIX_MAX       = 255;

    localparam logic [2:0] REG_TILE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_TILE_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_ROW_STEP      = 3'd2;
    localparam logic [2:0] REG_COL_STEP      = 3'd3;
    localparam logic [2:0] REG_RADIUS        = 3'd4;
    localparam logic [2:0] REG_ABS_MODE      = 3'd5;
    localparam logic [2:0] REG_VELOCITY_MODE = 3'd6;
    localparam logic [2:0] REG_INVERT        = 3'd7;

    typedef struct packed {
        logic [4:0] tile_width;
        logic [4:0] tile_height;
        logic [4:0] row_step;
        logic [4:0] col_step;
        logic [1:0] radius;
        logic       abs_mode;
        logic       velocity_mode;
        logic       invert;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLOSE,
        OP_CLR,
        OP_TILES_INIT,
        OP_NEXT_ROW,
        OP_TILE_START,
        OP_LAYER_BEGIN,
        OP_SUM_RD,
        OP_SUM_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_PIX_RD,
        OP_PIX_GET,
        OP_NB,
        OP_NB_FIN,
        OP_PIX_WR,
        OP_LAYER_END,
        OP_MAX,
        OP_MAX_FIN,
        OP_OUT_RD,
        OP_OUT_WR,
        OP_NEXT_TILE
    } dp_op_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic clr_last;
        logic warm;
        logic row_fits;
        logic col_fits;
        logic abs_mode;
        logic pix_last;
        logic div_last;
        logic first_layer;
        logic interior;
        logic nb_last;
        logic z_last;
        logic k_last;
    } dp_stat_t;

endpackage

### rtl/ttbd_ctrl.sv
module ttbd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ttbd_pkg::dp_stat_t  stat,
    output logic                busy,
    output ttbd_pkg::dp_cmd_t   cmd
);

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_CLR      = 20'h00002,
        S_TINIT    = 20'h00004,
        S_TCHK     = 20'h00008,
        S_LBEG     = 20'h00010,
        S_SUM_RD   = 20'h00020,
        S_SUM_ACC  = 20'h00040,
        S_DIV_INIT = 20'h00080,
        S_DIV      = 20'h00100,
        S_PIX_RD   = 20'h00200,
        S_PIX_GET  = 20'h00400,
        S_NB       = 20'h00800,
        S_NB_FIN   = 20'h01000,
        S_PIX_WR   = 20'h02000,
        S_LEND     = 20'h04000,
        S_MAX      = 20'h08000,
        S_MAX_FIN  = 20'h10000,
        S_ORD      = 20'h20000,
        S_OWR      = 20'h40000,
        S_TNEXT    = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.op     = ttbd_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = start;
                if (start && stat.last)
                begin
                    cmd.op     = ttbd_pkg::OP_CLOSE;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.op = ttbd_pkg::OP_CLR;
                if (stat.clr_last)
                    state_next = stat.warm ? S_TINIT : S_IDLE;
            end
            S_TINIT:
            begin
                cmd.op     = ttbd_pkg::OP_TILES_INIT;
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                if (!stat.row_fits)
                    state_next = S_IDLE;
                else if (!stat.col_fits)
                    cmd.op = ttbd_pkg::OP_NEXT_ROW;
                else
                begin
                    cmd.op     = ttbd_pkg::OP_TILE_START;
                    state_next = S_LBEG;
                end
            end
            S_LBEG:
            begin
                cmd.op     = ttbd_pkg::OP_LAYER_BEGIN;
                state_next = stat.abs_mode ? S_SUM_RD : S_PIX_RD;
            end
            S_SUM_RD:
            begin
                cmd.op     = ttbd_pkg::OP_SUM_RD;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.op     = ttbd_pkg::OP_SUM_ACC;
                state_next = stat.pix_last ? S_DIV_INIT : S_SUM_RD;
            end
            S_DIV_INIT:
            begin
                cmd.op     = ttbd_pkg::OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = ttbd_pkg::OP_DIV_STEP;
                if (stat.div_last)
                    state_next = S_PIX_RD;
            end
            S_PIX_RD:
            begin
                cmd.op     = ttbd_pkg::OP_PIX_RD;
                state_next = S_PIX_GET;
            end
            S_PIX_GET:
            begin
                cmd.op     = ttbd_pkg::OP_PIX_GET;
                state_next = (stat.first_layer || !stat.interior) ? S_PIX_WR : S_NB;
            end
            S_NB:
            begin
                cmd.op = ttbd_pkg::OP_NB;
                if (stat.nb_last)
                    state_next = S_NB_FIN;
            end
            S_NB_FIN:
            begin
                cmd.op     = ttbd_pkg::OP_NB_FIN;
                state_next = S_PIX_WR;
            end
            S_PIX_WR:
            begin
                cmd.op     = ttbd_pkg::OP_PIX_WR;
                state_next = stat.pix_last ? S_LEND : S_PIX_RD;
            end
            S_LEND:
            begin
                cmd.op     = ttbd_pkg::OP_LAYER_END;
                state_next = stat.z_last ? S_MAX : S_LBEG;
            end
            S_MAX:
            begin
                cmd.op = ttbd_pkg::OP_MAX;
                if (stat.k_last)
                    state_next = S_MAX_FIN;
            end
            S_MAX_FIN:
            begin
                cmd.op     = ttbd_pkg::OP_MAX_FIN;
                state_next = S_ORD;
            end
            S_ORD:
            begin
                cmd.op     = ttbd_pkg::OP_OUT_RD;
                state_next = S_OWR;
            end
            S_OWR:
            begin
                cmd.op     = ttbd_pkg::OP_OUT_WR;
                state_next = stat.pix_last ? S_TNEXT : S_ORD;
            end
            S_TNEXT:
            begin
                cmd.op     = ttbd_pkg::OP_NEXT_TILE;
                state_next = S_TCHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/ttbd_dp.sv
module ttbd_dp
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64,
    parameter int WINDOW       = 8,
    parameter int MAX_TILE     = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ttbd_pkg::cfg_t     cfg,
    input  logic [7:0]         pixel,
    input  logic               frame_end,
    input  ttbd_pkg::dp_cmd_t  cmd,
    output ttbd_pkg::dp_stat_t stat,
    output logic               result_valid,
    output logic [7:0]         out_pixel,
    output logic               warm,
    output logic               out_last
);

    localparam int FP     = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PIX_W  = $clog2(FP);
    localparam int FS_W   = $clog2(WINDOW * FP);
    localparam int SL_W   = $clog2(WINDOW);
    localparam int FH_W   = $clog2(WINDOW + 1);
    localparam int TD_W   = $clog2(MAX_TILE + 1);
    localparam int LD     = MAX_TILE * MAX_TILE;
    localparam int LI_W   = $clog2(LD);
    localparam int N_W    = $clog2(LD + 1);
    localparam int RO_W   = $clog2(MAX_TILE * FRAME_WIDTH);
    localparam int OI_W   = $clog2(FRAME_HEIGHT + 64);
    localparam int OJ_W   = $clog2(FRAME_WIDTH + 64);
    localparam int SUM_W  = 8 + N_W;
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = N_W + 1;
    localparam int DC_W   = $clog2(NUM_W);
    localparam int TW_LIM = (MAX_TILE < FRAME_WIDTH) ? MAX_TILE : FRAME_WIDTH;
    localparam int TH_LIM = (MAX_TILE < FRAME_HEIGHT) ? MAX_TILE : FRAME_HEIGHT;
    localparam int SW     = ttbd_pkg::SCORE_W;
    localparam int STW    = ttbd_pkg::STEP_W;

    logic [PIX_W-1:0] pos_reg;
    logic [SL_W-1:0]  wslot_reg;
    logic [FH_W-1:0]  fh_reg;
    logic             warm_reg;
    logic             first_reg;
    logic [TD_W-1:0]  tw_reg;
    logic [TD_W-1:0]  th_reg;
    logic [STW-1:0]   rs_reg;
    logic [STW-1:0]   cs_reg;
    logic [1:0]       rad_reg;
    logic             abs_reg;
    logic             vel_reg;
    logic             inv_reg;
    logic [N_W-1:0]   n_reg;
    logic [PIX_W-1:0] clr_reg;
    logic [OI_W-1:0]  oi_reg;
    logic [OJ_W-1:0]  oj_reg;
    logic [PIX_W-1:0] tile_base_reg;
    logic [FH_W-1:0]  z_reg;
    logic [SL_W-1:0]  slot_reg;
    logic             cur_reg;
    logic [FS_W-1:0]  slot_base_reg;
    logic [TD_W-1:0]  r_reg;
    logic [TD_W-1:0]  c_reg;
    logic [RO_W-1:0]  row_off_reg;
    logic [LI_W-1:0]  lay_row_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic [7:0]       pix_reg;
    logic [SW-1:0]    best_reg;
    logic [LI_W-1:0]  nb_row_reg;
    logic [2:0]       dr_reg;
    logic [2:0]       dc_reg;
    logic             nb_pend_reg;
    logic             mx_pend_reg;
    logic [SW-1:0]    maxv_reg;
    logic [LI_W-1:0]  k_reg;
    logic             val_reg;
    logic             olast_reg;
    logic             owarm_reg;
    logic             ozero_reg;
    logic             oinv_reg;

    logic [7:0]    frame_mem [WINDOW * FP];
    logic [7:0]    frame_rd_reg;
    logic [SW-1:0] lay_mem [2 ** (LI_W + 1)];
    logic [SW-1:0] lay_rd_reg;
    logic [7:0]    res_mem [FP];
    logic [7:0]    res_rd_reg;

    logic [10:0]      tw0, th0, tw1, th1;
    logic             small_tile, zero_step;
    logic [STW-1:0]   rs_e, cs_e;
    logic [FH_W-1:0]  fh_new;
    logic [SL_W-1:0]  oldest;
    logic             last;
    logic             pix_last;
    logic             z_last;
    logic             interior;
    logic [2:0]       span;
    logic [FS_W-1:0]  fw_addr;
    logic [FS_W-1:0]  fr_addr;
    logic [LI_W:0]    lr_addr;
    logic [LI_W:0]    lw_addr;
    logic [SW-1:0]    lw_data;
    logic             lw_en;
    logic [PIX_W-1:0] rr_addr;
    logic [PIX_W-1:0] tile_addr;
    logic [PIX_W-1:0] rw_addr;
    logic [7:0]       rw_data;
    logic             rw_en;
    logic [7:0]       mean;
    logic [7:0]       pix_val;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [7:0]       o_val;
    logic [8:0]       s_val;

    always_comb
    begin
        small_tile = (cfg.tile_width < 5'(ttbd_pkg::MIN_TILE))
                  || (cfg.tile_height < 5'(ttbd_pkg::MIN_TILE));
        tw0 = small_tile ? 11'(ttbd_pkg::DEF_TILE) : 11'(cfg.tile_width);
        th0 = small_tile ? 11'(ttbd_pkg::DEF_TILE) : 11'(cfg.tile_height);
        tw1 = (tw0 > 11'(TW_LIM)) ? 11'(TW_LIM) : tw0;
        th1 = (th0 > 11'(TH_LIM)) ? 11'(TH_LIM) : th0;
        zero_step = (cfg.row_step == 5'd0) || (cfg.col_step == 5'd0);
        rs_e = zero_step ? STW'(tw1) : STW'(cfg.row_step);
        cs_e = zero_step ? STW'(th1) : STW'(cfg.col_step);
    end

    assign fh_new = (int'(fh_reg) < WINDOW) ? FH_W'(fh_reg + 1'b1) : fh_reg;
    assign oldest = (int'(wslot_reg) + WINDOW - int'(fh_reg) >= WINDOW)
                  ? SL_W'(int'(wslot_reg) - int'(fh_reg))
                  : SL_W'(int'(wslot_reg) + WINDOW - int'(fh_reg));

    assign last     = frame_end || (int'(pos_reg) == FP - 1);
    assign pix_last = (int'(r_reg) == int'(th_reg) - 1) && (int'(c_reg) == int'(tw_reg) - 1);
    assign z_last   = (int'(z_reg) == int'(fh_reg) - 1);
    assign interior = (int'(r_reg) >= int'(rad_reg)) && (int'(r_reg) + int'(rad_reg) < int'(th_reg))
                   && (int'(c_reg) >= int'(rad_reg)) && (int'(c_reg) + int'(rad_reg) < int'(tw_reg));
    assign span     = {rad_reg, 1'b0};

    always_comb
    begin
        stat.last        = last;
        stat.clr_last    = (int'(clr_reg) == FP - 1);
        stat.warm        = warm_reg;
        stat.row_fits    = (int'(oi_reg) + int'(th_reg) <= FRAME_HEIGHT);
        stat.col_fits    = (int'(oj_reg) + int'(tw_reg) <= FRAME_WIDTH);
        stat.abs_mode    = abs_reg;
        stat.pix_last    = pix_last;
        stat.div_last    = (dcnt_reg == '0);
        stat.first_layer = (z_reg == '0);
        stat.interior    = interior;
        stat.nb_last     = (dr_reg == span) && (dc_reg == span);
        stat.z_last      = z_last;
        stat.k_last      = (int'(k_reg) == int'(n_reg) - 1);
    end

    assign mean    = quo_reg[7:0];
    assign pix_val = !abs_reg ? frame_rd_reg
                   : (frame_rd_reg > mean) ? 8'(frame_rd_reg - mean) : 8'(mean - frame_rd_reg);
    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = (trial >= {1'b0, n_reg, 1'b0});

    // Frame store: written by the incoming beat, read while the tile is loaded.
    assign fw_addr   = FS_W'(int'(wslot_reg) * FP + int'(pos_reg));
    assign fr_addr   = FS_W'(slot_base_reg + row_off_reg + c_reg);
    assign tile_addr = PIX_W'(tile_base_reg + row_off_reg + c_reg);

    always_comb
    begin
        if (cmd.op == ttbd_pkg::OP_NB)
            lr_addr = {~cur_reg, LI_W'(nb_row_reg + c_reg - rad_reg + dc_reg)};
        else if (cmd.op == ttbd_pkg::OP_MAX)
            lr_addr = {cur_reg, k_reg};
        else
            lr_addr = {cur_reg, LI_W'(lay_row_reg + c_reg)};
    end

    assign lw_addr = {cur_reg, LI_W'(lay_row_reg + c_reg)};
    assign lw_en   = (cmd.op == ttbd_pkg::OP_PIX_WR);
    assign lw_data = (z_reg == '0) ? SW'(pix_reg)
                   : interior ? SW'(SW'(pix_reg) + best_reg) : '0;

    // Newest layer goes either saturated or through the threshold against the tile max.
    always_comb
    begin
        if (vel_reg)
            o_val = (lay_rd_reg > SW'(ttbd_pkg::PIX_MAX)) ? 8'(ttbd_pkg::PIX_MAX) : lay_rd_reg[7:0];
        else
            o_val = ({1'b0, lay_rd_reg} + (SW + 1)'(ttbd_pkg::THRESH_OFFSET) > {1'b0, maxv_reg})
                  ? 8'(ttbd_pkg::PIX_MAX) : 8'd0;
        s_val = {1'b0, res_rd_reg} + {1'b0, o_val};
    end

    assign rr_addr = cmd.accept ? pos_reg : tile_addr;
    assign rw_en   = (cmd.op == ttbd_pkg::OP_CLR) || (cmd.op == ttbd_pkg::OP_OUT_WR);
    assign rw_addr = (cmd.op == ttbd_pkg::OP_CLR) ? clr_reg : tile_addr;
    assign rw_data = (cmd.op == ttbd_pkg::OP_CLR) ? 8'd0
                   : s_val[8] ? 8'(ttbd_pkg::PIX_MAX) : s_val[7:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            frame_mem[fw_addr] <= pixel;
        frame_rd_reg <= frame_mem[fr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
            lay_mem[lw_addr] <= lw_data;
        lay_rd_reg <= lay_mem[lr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rw_en)
            res_mem[rw_addr] <= rw_data;
        res_rd_reg <= res_mem[rr_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            wslot_reg     <= '0;
            fh_reg        <= '0;
            warm_reg      <= 1'b0;
            first_reg     <= 1'b0;
            tw_reg        <= '0;
            th_reg        <= '0;
            rs_reg        <= '0;
            cs_reg        <= '0;
            rad_reg       <= '0;
            abs_reg       <= 1'b0;
            vel_reg       <= 1'b0;
            inv_reg       <= 1'b0;
            n_reg         <= '0;
            clr_reg       <= '0;
            oi_reg        <= '0;
            oj_reg        <= '0;
            tile_base_reg <= '0;
            z_reg         <= '0;
            slot_reg      <= '0;
            cur_reg       <= 1'b0;
            slot_base_reg <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            row_off_reg   <= '0;
            lay_row_reg   <= '0;
            sum_reg       <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= '0;
            pix_reg       <= '0;
            best_reg      <= '0;
            nb_row_reg    <= '0;
            dr_reg        <= '0;
            dc_reg        <= '0;
            nb_pend_reg   <= 1'b0;
            mx_pend_reg   <= 1'b0;
            maxv_reg      <= '0;
            k_reg         <= '0;
            val_reg       <= 1'b0;
            olast_reg     <= 1'b0;
            owarm_reg     <= 1'b0;
            ozero_reg     <= 1'b1;
            oinv_reg      <= 1'b0;
        end
        else
        begin
            val_reg <= cmd.accept;
            if (cmd.accept)
            begin
                olast_reg <= last;
                owarm_reg <= warm_reg;
                ozero_reg <= !first_reg;
                oinv_reg  <= inv_reg;
                pos_reg   <= last ? '0 : PIX_W'(pos_reg + 1'b1);
            end

            nb_pend_reg <= (cmd.op == ttbd_pkg::OP_NB);
            mx_pend_reg <= (cmd.op == ttbd_pkg::OP_MAX);
            if (nb_pend_reg && (lay_rd_reg > best_reg))
                best_reg <= lay_rd_reg;
            if (mx_pend_reg && (lay_rd_reg > maxv_reg))
                maxv_reg <= lay_rd_reg;

            case (cmd.op)
                ttbd_pkg::OP_CLOSE:
                begin
                    wslot_reg <= (int'(wslot_reg) == WINDOW - 1) ? '0 : SL_W'(wslot_reg + 1'b1);
                    fh_reg    <= fh_new;
                    warm_reg  <= (int'(fh_new) > ttbd_pkg::MIN_LAYERS);
                    first_reg <= 1'b1;
                    tw_reg    <= TD_W'(tw1);
                    th_reg    <= TD_W'(th1);
                    rs_reg    <= rs_e;
                    cs_reg    <= cs_e;
                    rad_reg   <= cfg.radius;
                    abs_reg   <= cfg.abs_mode;
                    vel_reg   <= cfg.velocity_mode;
                    inv_reg   <= cfg.invert;
                    n_reg     <= N_W'(tw1 * th1);
                    clr_reg   <= '0;
                end
                ttbd_pkg::OP_CLR:
                begin
                    clr_reg <= PIX_W'(clr_reg + 1'b1);
                end
                ttbd_pkg::OP_TILES_INIT:
                begin
                    oi_reg <= '0;
                    oj_reg <= '0;
                end
                ttbd_pkg::OP_NEXT_ROW:
                begin
                    oi_reg <= OI_W'(oi_reg + rs_reg);
                    oj_reg <= '0;
                end
                ttbd_pkg::OP_TILE_START:
                begin
                    tile_base_reg <= PIX_W'(int'(oi_reg) * FRAME_WIDTH + int'(oj_reg));
                    z_reg         <= '0;
                    slot_reg      <= oldest;
                    cur_reg       <= 1'b0;
                    r_reg         <= '0;
                    c_reg         <= '0;
                    row_off_reg   <= '0;
                    lay_row_reg   <= '0;
                end
                ttbd_pkg::OP_LAYER_BEGIN:
                begin
                    slot_base_reg <= FS_W'(int'(slot_reg) * FP + int'(tile_base_reg));
                    sum_reg       <= '0;
                end
                ttbd_pkg::OP_SUM_ACC:
                begin
                    sum_reg <= SUM_W'(sum_reg + frame_rd_reg);
                end
                ttbd_pkg::OP_DIV_INIT:
                begin
                    num_reg  <= NUM_W'({sum_reg, 1'b0}) + NUM_W'(n_reg);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    dcnt_reg <= DC_W'(NUM_W - 1);
                end
                ttbd_pkg::OP_DIV_STEP:
                begin
                    rem_reg  <= ge ? DEN_W'(trial - {1'b0, n_reg, 1'b0}) : DEN_W'(trial);
                    quo_reg  <= {quo_reg[NUM_W-2:0], ge};
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    dcnt_reg <= DC_W'(dcnt_reg - 1'b1);
                end
                ttbd_pkg::OP_PIX_GET:
                begin
                    pix_reg    <= pix_val;
                    best_reg   <= '0;
                    nb_row_reg <= LI_W'(lay_row_reg - rad_reg * tw_reg);
                    dr_reg     <= '0;
                    dc_reg     <= '0;
                end
                ttbd_pkg::OP_NB:
                begin
                    if (dc_reg == span)
                    begin
                        dc_reg     <= '0;
                        dr_reg     <= 3'(dr_reg + 1'b1);
                        nb_row_reg <= LI_W'(nb_row_reg + tw_reg);
                    end
                    else
                        dc_reg <= 3'(dc_reg + 1'b1);
                end
                ttbd_pkg::OP_LAYER_END:
                begin
                    z_reg    <= FH_W'(z_reg + 1'b1);
                    slot_reg <= (int'(slot_reg) == WINDOW - 1) ? '0 : SL_W'(slot_reg + 1'b1);
                    if (!z_last)
                        cur_reg <= ~cur_reg;
                    maxv_reg <= '0;
                    k_reg    <= '0;
                end
                ttbd_pkg::OP_MAX:
                begin
                    k_reg <= LI_W'(k_reg + 1'b1);
                end
                ttbd_pkg::OP_NEXT_TILE:
                begin
                    oj_reg <= OJ_W'(oj_reg + cs_reg);
                end
                default:
                begin
                end
            endcase

            // The tile walk steps one pixel on each accumulate, layer write or result write.
            if ((cmd.op == ttbd_pkg::OP_SUM_ACC) || (cmd.op == ttbd_pkg::OP_PIX_WR)
                || (cmd.op == ttbd_pkg::OP_OUT_WR))
            begin
                if (int'(c_reg) == int'(tw_reg) - 1)
                begin
                    c_reg <= '0;
                    if (int'(r_reg) == int'(th_reg) - 1)
                    begin
                        r_reg       <= '0;
                        row_off_reg <= '0;
                        lay_row_reg <= '0;
                    end
                    else
                    begin
                        r_reg       <= TD_W'(r_reg + 1'b1);
                        row_off_reg <= RO_W'(int'(row_off_reg) + FRAME_WIDTH);
                        lay_row_reg <= LI_W'(lay_row_reg + tw_reg);
                    end
                end
                else
                    c_reg <= TD_W'(c_reg + 1'b1);
            end
        end
    end

    assign result_valid = val_reg;
    assign out_pixel    = ozero_reg ? 8'd0 : (res_rd_reg ^ {8{oinv_reg}});
    assign warm         = owarm_reg;
    assign out_last     = olast_reg;

endmodule

### rtl/tiled_track_before_detect_filter.sv
// A result beat appears in the cycle after its pixel is taken (start high, busy low).
// A pixel that does not close a frame leaves busy low, so pixels may follow back to back.
// A closing pixel holds busy while the result store is cleared; once the window is warm it then
// walks each tile through every held layer (abs mode first takes the tile mean) and a neighbourhood
// max of (2*radius+1)^2 cells per interior pixel after layer 0, then the tile max and result writes.
// Reset clears control state and loads register defaults; results read zero until a frame closes.
module tiled_track_before_detect_filter
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64,
    parameter int WINDOW       = 8,
    parameter int MAX_TILE     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  pixel,
    input  logic        frame_end,
    output logic        result_valid,
    output logic [7:0]  out_pixel,
    output logic        warm,
    output logic        out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ttbd_pkg::cfg_t     cfg_reg;
    ttbd_pkg::dp_cmd_t  cmd;
    ttbd_pkg::dp_stat_t stat;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width    <= 5'd10;
            cfg_reg.tile_height   <= 5'd10;
            cfg_reg.row_step      <= 5'd10;
            cfg_reg.col_step      <= 5'd10;
            cfg_reg.radius        <= 2'd1;
            cfg_reg.abs_mode      <= 1'b0;
            cfg_reg.velocity_mode <= 1'b0;
            cfg_reg.invert        <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                ttbd_pkg::REG_TILE_WIDTH:    cfg_reg.tile_width    <= pwdata[4:0];
                ttbd_pkg::REG_TILE_HEIGHT:   cfg_reg.tile_height   <= pwdata[4:0];
                ttbd_pkg::REG_ROW_STEP:      cfg_reg.row_step      <= pwdata[4:0];
                ttbd_pkg::REG_COL_STEP:      cfg_reg.col_step      <= pwdata[4:0];
                ttbd_pkg::REG_RADIUS:        cfg_reg.radius        <= pwdata[1:0];
                ttbd_pkg::REG_ABS_MODE:      cfg_reg.abs_mode      <= pwdata[0];
                ttbd_pkg::REG_VELOCITY_MODE: cfg_reg.velocity_mode <= pwdata[0];
                ttbd_pkg::REG_INVERT:        cfg_reg.invert        <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            ttbd_pkg::REG_TILE_WIDTH:    prdata = 32'(cfg_reg.tile_width);
            ttbd_pkg::REG_TILE_HEIGHT:   prdata = 32'(cfg_reg.tile_height);
            ttbd_pkg::REG_ROW_STEP:      prdata = 32'(cfg_reg.row_step);
            ttbd_pkg::REG_COL_STEP:      prdata = 32'(cfg_reg.col_step);
            ttbd_pkg::REG_RADIUS:        prdata = 32'(cfg_reg.radius);
            ttbd_pkg::REG_ABS_MODE:      prdata = 32'(cfg_reg.abs_mode);
            ttbd_pkg::REG_VELOCITY_MODE: prdata = 32'(cfg_reg.velocity_mode);
            ttbd_pkg::REG_INVERT:        prdata = 32'(cfg_reg.invert);
            default:                     prdata = 32'd0;
        endcase
    end

    ttbd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    ttbd_dp
    #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .WINDOW       (WINDOW),
        .MAX_TILE     (MAX_TILE)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pixel        (pixel),
        .frame_end    (frame_end),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .out_pixel    (out_pixel),
        .warm         (warm),
        .out_last     (out_last)
    );

    // Every result beat answers exactly one accepted pixel beat.
    a_result_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy))
        else $error("result beat without an accepted pixel");

    // A frame_end beat always starts the frame close.
    a_close_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && frame_end) |=> busy)
        else $error("frame close did not raise busy");

    // The closing beat of a frame is the one flagged as out_last.
    a_last_marks_close : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_last) |-> busy)
        else $error("out_last beat without a frame close");

    // Nothing is accepted while a frame close is running.
    a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        $past(busy) && busy |-> !result_valid)
        else $error("result beat while busy");

endmodule

### tb/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = 64;
    localparam int FH = 64;
    localparam int NPIX = FW * FH;
    localparam int WIN = 8;
    localparam int TMAX = 16;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [7:0] pix;
        logic       fend;
    } pixel_beat_t;

    typedef struct {
        logic [7:0] pix;
        logic       warm;
        logic       last;
    } result_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  pixel = 8'd0;
    logic        frame_end = 1'b0;
    logic        result_valid;
    logic [7:0]  out_pixel;
    logic        warm;
    logic        out_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    tiled_track_before_detect_filter uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel(pixel), .frame_end(frame_end),
        .result_valid(result_valid), .out_pixel(out_pixel), .warm(warm),
        .out_last(out_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pixel_beat_t  pending_pixels[$];
    result_beat_t expected_results[$];
    int           idle_pct = 0;
    int           mismatches = 0;
    int           pixels_taken = 0;
    int           frames_closed = 0;
    int           warm_frames = 0;
    longint       cycles = 0;

    // Filter state as the predictor sees it.
    byte unsigned held_frames[WIN][NPIX];
    byte unsigned shown_frame[NPIX];
    int           score[2][TMAX*TMAX];
    int           tile_pix[TMAX*TMAX];
    int           n_held = 0;
    int           raster_pos = 0;
    int           write_slot = 0;
    bit           warm_now = 1'b0;
    int           cfg_val[8] = '{10, 10, 10, 10, 1, 0, 0, 0};

    function automatic void fetch_tile(int slot, int oi, int oj, int tw, int th);
        int sum;
        int n;
        int m;
        sum = 0;
        n = tw * th;
        for (int r = 0; r < th; r++)
            for (int c = 0; c < tw; c++)
            begin
                tile_pix[r*tw + c] = held_frames[slot][(oi + r)*FW + oj + c];
                sum += tile_pix[r*tw + c];
            end
        if (cfg_val[ttbd_pkg::REG_ABS_MODE] != 0)
        begin
            m = (2*sum + n) / (2*n);
            for (int k = 0; k < n; k++)
                tile_pix[k] = (tile_pix[k] > m) ? tile_pix[k] - m : m - tile_pix[k];
        end
    endfunction

    function automatic void track_tile(int oi, int oj, int tw, int th);
        int n;
        int cur;
        int rad;
        int best;
        int peak;
        int v;
        int o;
        int idx;
        n = tw * th;
        cur = 0;
        rad = cfg_val[ttbd_pkg::REG_RADIUS];
        peak = 0;
        for (int z = 0; z < n_held; z++)
        begin
            fetch_tile((write_slot + WIN - n_held + z) % WIN, oi, oj, tw, th);
            cur = z & 1;
            if (z == 0)
            begin
                for (int k = 0; k < n; k++)
                    score[cur][k] = tile_pix[k];
            end
            else
            begin
                for (int k = 0; k < TMAX*TMAX; k++)
                    score[cur][k] = 0;
                for (int r = rad; r < th - rad; r++)
                    for (int c = rad; c < tw - rad; c++)
                    begin
                        best = 0;
                        for (int dr = -rad; dr <= rad; dr++)
                            for (int dc = -rad; dc <= rad; dc++)
                                if (score[cur ^ 1][(r + dr)*tw + c + dc] > best)
                                    best = score[cur ^ 1][(r + dr)*tw + c + dc];
                        score[cur][r*tw + c] = (tile_pix[r*tw + c] + best) & 16'hffff;
                    end
            end
        end
        for (int k = 0; k < n; k++)
            if (score[cur][k] > peak)
                peak = score[cur][k];
        for (int r = 0; r < th; r++)
            for (int c = 0; c < tw; c++)
            begin
                v = score[cur][r*tw + c];
                if (cfg_val[ttbd_pkg::REG_VELOCITY_MODE] != 0)
                    o = (v > ttbd_pkg::PIX_MAX) ? ttbd_pkg::PIX_MAX : v;
                else
                    o = (v > peak - ttbd_pkg::THRESH_OFFSET) ? ttbd_pkg::PIX_MAX : 0;
                idx = (oi + r)*FW + oj + c;
                o += shown_frame[idx];
                shown_frame[idx] = 8'((o > ttbd_pkg::PIX_MAX) ? ttbd_pkg::PIX_MAX : o);
            end
    endfunction

    function automatic void finish_frame();
        int tw;
        int th;
        int rs;
        int cs;
        tw = cfg_val[ttbd_pkg::REG_TILE_WIDTH];
        th = cfg_val[ttbd_pkg::REG_TILE_HEIGHT];
        rs = cfg_val[ttbd_pkg::REG_ROW_STEP];
        cs = cfg_val[ttbd_pkg::REG_COL_STEP];
        if (tw < ttbd_pkg::MIN_TILE || th < ttbd_pkg::MIN_TILE)
        begin
            tw = ttbd_pkg::DEF_TILE;
            th = ttbd_pkg::DEF_TILE;
        end
        if (tw > TMAX) tw = TMAX;
        if (th > TMAX) th = TMAX;
        if (rs < 1 || cs < 1)
        begin
            rs = tw;
            cs = th;
        end
        write_slot = (write_slot + 1) % WIN;
        if (n_held < WIN) n_held++;
        for (int k = 0; k < NPIX; k++)
            shown_frame[k] = 0;
        warm_now = (n_held > ttbd_pkg::MIN_LAYERS);
        if (warm_now)
        begin
            warm_frames++;
            for (int oi = 0; oi + th <= FH; oi += rs)
                for (int oj = 0; oj + tw <= FW; oj += cs)
                    track_tile(oi, oj, tw, th);
        end
        if (cfg_val[ttbd_pkg::REG_INVERT] != 0)
            for (int k = 0; k < NPIX; k++)
                shown_frame[k] = ~shown_frame[k];
    endfunction

    function automatic result_beat_t filter_pixel(pixel_beat_t b);
        result_beat_t res;
        res.pix = shown_frame[raster_pos];
        res.warm = warm_now;
        res.last = b.fend || (raster_pos == NPIX - 1);
        held_frames[write_slot][raster_pos] = b.pix;
        if (res.last)
        begin
            finish_frame();
            frames_closed++;
            raster_pos = 0;
        end
        else
            raster_pos++;
        return res;
    endfunction

    // Pixel driver: inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && pending_pixels.size() > 0)
        begin
            start <= ($urandom_range(99) >= idle_pct);
            pixel <= pending_pixels[0].pix;
            frame_end <= pending_pixels[0].fend;
        end
        else
            start <= 1'b0;
    end

    // Monitor: results are checked before the new beat is predicted.
    always @(posedge clk)
    begin
        result_beat_t e;
        pixel_beat_t  taken;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tiled_track_before_detect_filter: mismatch");
            $finish;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: pix %0d", out_pixel);
                end
                else
                begin
                    e = expected_results[0];
                    expected_results.delete(0);
                    if (out_pixel !== e.pix || warm !== e.warm || out_last !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: exp pix %0d warm %0b last %0b, got %0d %0b %0b",
                                     pixels_taken, e.pix, e.warm, e.last,
                                     out_pixel, warm, out_last);
                    end
                end
            end
            if (start && !busy)
            begin
                taken = pending_pixels[0];
                pending_pixels.delete(0);
                expected_results = {expected_results, filter_pixel(taken)};
                pixels_taken++;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ttbd_pkg::REG_RADIUS: cfg_val[idx] = val & 3;
            ttbd_pkg::REG_ABS_MODE, ttbd_pkg::REG_VELOCITY_MODE, ttbd_pkg::REG_INVERT:
                cfg_val[idx] = val & 1;
            default: cfg_val[idx] = val & 31;
        endcase
    endtask

    task automatic write_setting(int w, int h, int rs, int cs, int rad, int ab, int vel,
                                 int inv);
        write_reg(ttbd_pkg::REG_TILE_WIDTH, w);
        write_reg(ttbd_pkg::REG_TILE_HEIGHT, h);
        write_reg(ttbd_pkg::REG_ROW_STEP, rs);
        write_reg(ttbd_pkg::REG_COL_STEP, cs);
        write_reg(ttbd_pkg::REG_RADIUS, rad);
        write_reg(ttbd_pkg::REG_ABS_MODE, ab);
        write_reg(ttbd_pkg::REG_VELOCITY_MODE, vel);
        write_reg(ttbd_pkg::REG_INVERT, inv);
    endtask

    // Queues one frame and lets it drain; a frame ends on frame_end or by running full.
    task automatic send_frame(int len, bit close_flag);
        pixel_beat_t b;
        int sel;
        for (int i = 0; i < len; i++)
        begin
            sel = $urandom_range(7);
            b.pix = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(255));
            b.fend = (i == len - 1) ? close_flag : 1'b0;
            pending_pixels = {pending_pixels, b};
        end
        while (pending_pixels.size() > 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        while (expected_results.size() > 0 || busy)
            @(posedge clk);
    endtask

    int idle_plan[7] = '{0, 58, 13, 0, 58, 13, 0};

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot of the window with whole frames so later short frames only
        // overwrite known data.
        write_setting(5, 5, 16, 16, 0, 0, 1, 0);
        for (int f = 0; f < WIN; f++)
        begin
            idle_pct = idle_plan[f % 7];
            send_frame(NPIX, f[0]);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_setting(10, 10, 16, 16, 1, 0, 0, 0);
                1: write_setting(16, 5, 16, 16, 2, 1, 0, 1);
                // Tile too large for the radius: later layers have no interior.
                2: write_setting(5, 5, 1, 31, 3, 1, 1, 0);
                // Undersized tile falls back to the default and a zero step follows the tile.
                3: write_setting(31, 3, 0, 7, 0, 0, 0, 0);
                4: write_setting(5, 5, 31, 1, 2, 0, 0, 1);
                default: write_setting(20, 31, 16, 16, 0, 1, 1, 1);
            endcase
            for (int f = 0; f < 2; f++)
            begin
                idle_pct = idle_plan[(ph*2 + f) % 7];
                send_frame($urandom_range(60, 250), 1'b1);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_results.size() > 0)
            mismatches++;
        $display("%0d pixels in %0d frames (%0d past warm-up) over 7 register settings",
                 pixels_taken, frames_closed, warm_frames);
        $display("%0d mismatching beats", mismatches);
        if (mismatches == 0)
            $display("tiled_track_before_detect_filter: match");
        else
            $display("tiled_track_before_detect_filter: mismatch");
        $finish;
    end
endmodule

### files.f
rtl/ttbd_pkg.sv
rtl/ttbd_ctrl.sv
rtl/ttbd_dp.sv
rtl/tiled_track_before_detect_filter.sv
tb/tb.sv
